// ===== hw/rtl/ptzs_pkg.sv =====
// Shared types and constants for the preset tour sequencer.
// Holds command codes, status codes, register indexes and the
// controller to datapath command and status structs.
package ptzs_pkg;

   localparam int CHANNELS = 16;
   localparam int TOURS    = 8;
   localparam int POINTS   = 16;

   localparam int CH_W     = 4;
   localparam int TOUR_W   = 3;
   localparam int POINT_W  = 4;
   localparam int ADDR_W   = CH_W + TOUR_W + POINT_W;
   localparam int DEPTH    = CHANNELS * TOURS * POINTS;
   localparam int ENTRY_W  = 24;

   localparam logic [31:0] IDLE_DUE = 32'h7fff_ffff;

   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_ENTER  = 3'd1;
   localparam logic [2:0] CMD_SET    = 3'd2;
   localparam logic [2:0] CMD_LEAVE  = 3'd3;
   localparam logic [2:0] CMD_RUN    = 3'd4;
   localparam logic [2:0] CMD_STOP   = 3'd5;
   localparam logic [2:0] CMD_DELETE = 3'd6;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_CH   = 3'd1;
   localparam logic [2:0] ST_BAD_TOUR = 3'd2;
   localparam logic [2:0] ST_RUNNING  = 3'd3;
   localparam logic [2:0] ST_CURSOR   = 3'd4;

   localparam logic [1:0] CSR_CHAN_COUNT = 2'd0;
   localparam logic [1:0] CSR_EMU_MASK   = 2'd1;
   localparam logic [1:0] CSR_DWELL_GAP  = 2'd2;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_CLEAR,
      ACT_LOAD,
      ACT_DECODE,
      ACT_UNUSE,
      ACT_GO,
      ACT_GO_NEXT,
      ACT_SCAN,
      ACT_REARM,
      ACT_PUBLISH
   } act_type;

   typedef enum logic [2:0] {
      RT_DONE,
      RT_UNUSE,
      RT_GO,
      RT_JUMP,
      RT_SCAN
   } route_type;

   typedef struct packed {
      act_type act;
   } dp_cmd_type;

   typedef struct packed {
      logic      clr_last;
      route_type route;
      logic      ptr_end;
      logic      rd_used;
      logic      ptr_last;
      logic      out_free;
   } dp_stat_type;

endpackage

// ===== hw/rtl/ptzs_datapath.sv =====
// Datapath of the preset tour sequencer: tour memories, per-channel
// cursors and due times, configuration and result registers.
// Depends on ptzs_pkg; driven by ptzs_ctrl.
module ptzs_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  ptzs_pkg::dp_cmd_type        cmd_in,
   output ptzs_pkg::dp_stat_type       stat_out,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [31:0]                 csr_wdata,
   input  logic [2:0]                  req_cmd,
   input  logic [3:0]                  req_channel,
   input  logic [7:0]                  req_tour_id,
   input  logic [7:0]                  req_preset_id,
   input  logic [7:0]                  req_move_speed,
   input  logic [7:0]                  req_dwell_time,
   input  logic [31:0]                 req_now_time,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [2:0]                  rsp_status,
   output logic                        rsp_handled,
   output logic                        rsp_go_valid,
   output logic [3:0]                  rsp_go_channel,
   output logic [7:0]                  rsp_go_preset,
   output logic [7:0]                  rsp_go_speed,
   output logic [7:0]                  rsp_go_dwell
);

   logic [ptzs_pkg::ENTRY_W-1:0] data_mem [ptzs_pkg::DEPTH];
   logic                         used_mem [ptzs_pkg::DEPTH];
   logic [ptzs_pkg::ENTRY_W-1:0] rd_data_ff;
   logic                         rd_used_ff;

   logic [ptzs_pkg::ADDR_W-1:0]  clr_cnt_ff;

   logic [2:0]  cmd_ff;
   logic [3:0]  ch_ff;
   logic [7:0]  tour_ff;
   logic [7:0]  preset_ff;
   logic [7:0]  speed_ff;
   logic [7:0]  dwell_ff;
   logic [31:0] now_ff;

   logic [4:0]  chan_count_ff;
   logic [15:0] emu_mask_ff;
   logic [31:0] gap_ff;

   logic                             prog_valid_ff [ptzs_pkg::CHANNELS];
   logic [ptzs_pkg::TOUR_W-1:0]      prog_tour_ff  [ptzs_pkg::CHANNELS];
   logic [ptzs_pkg::POINT_W:0]       prog_point_ff [ptzs_pkg::CHANNELS];
   logic                             running_ff    [ptzs_pkg::CHANNELS];
   logic [ptzs_pkg::TOUR_W-1:0]      run_tour_ff   [ptzs_pkg::CHANNELS];
   logic [ptzs_pkg::POINT_W-1:0]     run_point_ff  [ptzs_pkg::CHANNELS];
   logic [31:0]                      next_due_ff   [ptzs_pkg::CHANNELS];

   logic [ptzs_pkg::TOUR_W-1:0]  tsel_ff;
   logic [ptzs_pkg::POINT_W:0]   ptr_ff;
   ptzs_pkg::route_type          route_ff;

   logic [2:0] res_status_ff;
   logic       res_handled_ff;
   logic       res_go_valid_ff;
   logic [7:0] res_preset_ff;
   logic [7:0] res_speed_ff;
   logic [7:0] res_dwell_ff;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic        rsp_handled_ff;
   logic        rsp_go_valid_ff;
   logic [3:0]  rsp_go_channel_ff;
   logic [7:0]  rsp_go_preset_ff;
   logic [7:0]  rsp_go_speed_ff;
   logic [7:0]  rsp_go_dwell_ff;

   logic [ptzs_pkg::ADDR_W-1:0] rd_addr;
   logic [ptzs_pkg::ADDR_W-1:0] set_addr;
   logic                        bad_ch;
   logic                        bad_tour;
   logic                        emulated;
   logic [31:0]                 next_cur;
   logic [31:0]                 late_gap;
   logic [31:0]                 early_gap;
   logic                        is_late;
   logic [31:0]                 rearm_due;

   assign rd_addr   = {ch_ff, tsel_ff, ptr_ff[ptzs_pkg::POINT_W-1:0]};
   assign set_addr  = {ch_ff, prog_tour_ff[ch_ff],
                       prog_point_ff[ch_ff][ptzs_pkg::POINT_W-1:0]};
   assign bad_ch    = ({1'b0, ch_ff} >= chan_count_ff);
   assign bad_tour  = (tour_ff >= 8'(ptzs_pkg::TOURS));
   assign emulated  = emu_mask_ff[ch_ff];
   assign next_cur  = next_due_ff[ch_ff];
   assign late_gap  = now_ff - next_cur;
   assign early_gap = next_cur - now_ff;
   assign is_late   = (now_ff > next_cur);
   assign rearm_due = now_ff + {24'd0, rd_data_ff[7:0]};

   assign stat_out.clr_last = (clr_cnt_ff == ptzs_pkg::ADDR_W'(ptzs_pkg::DEPTH - 1));
   assign stat_out.route    = route_ff;
   assign stat_out.ptr_end  = ptr_ff[ptzs_pkg::POINT_W];
   assign stat_out.rd_used  = rd_used_ff;
   assign stat_out.ptr_last = (ptr_ff[ptzs_pkg::POINT_W-1:0] ==
                               ptzs_pkg::POINT_W'(ptzs_pkg::POINTS - 1));
   assign stat_out.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      rd_data_ff <= data_mem[rd_addr];
      rd_used_ff <= used_mem[rd_addr];
      if (cmd_in.act == ptzs_pkg::ACT_CLEAR) begin
         data_mem[clr_cnt_ff] <= '0;
         used_mem[clr_cnt_ff] <= 1'b0;
      end else if (cmd_in.act == ptzs_pkg::ACT_DECODE && cmd_ff == ptzs_pkg::CMD_SET &&
                   !bad_ch && prog_valid_ff[ch_ff] &&
                   !prog_point_ff[ch_ff][ptzs_pkg::POINT_W]) begin
         data_mem[set_addr] <= {preset_ff, speed_ff, dwell_ff};
         used_mem[set_addr] <= 1'b1;
      end else if (cmd_in.act == ptzs_pkg::ACT_UNUSE && !ptr_ff[ptzs_pkg::POINT_W]) begin
         used_mem[rd_addr] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff    <= '0;
         chan_count_ff <= 5'd16;
         emu_mask_ff   <= '0;
         gap_ff        <= 32'd255;
         rsp_valid_ff  <= 1'b0;
         route_ff      <= ptzs_pkg::RT_DONE;
         for (int c = 0; c < ptzs_pkg::CHANNELS; c++) begin
            prog_valid_ff[c] <= 1'b0;
            prog_tour_ff[c]  <= '0;
            prog_point_ff[c] <= '0;
            running_ff[c]    <= 1'b0;
            run_tour_ff[c]   <= '0;
            run_point_ff[c]  <= '0;
            next_due_ff[c]   <= ptzs_pkg::IDLE_DUE;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               ptzs_pkg::CSR_CHAN_COUNT: chan_count_ff <= csr_wdata[4:0];
               ptzs_pkg::CSR_EMU_MASK:   emu_mask_ff   <= csr_wdata[15:0];
               ptzs_pkg::CSR_DWELL_GAP:  gap_ff        <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && cmd_in.act != ptzs_pkg::ACT_PUBLISH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd_in.act)
            ptzs_pkg::ACT_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
            end
            ptzs_pkg::ACT_LOAD: begin
               cmd_ff          <= req_cmd;
               ch_ff           <= req_channel;
               tour_ff         <= req_tour_id;
               preset_ff       <= req_preset_id;
               speed_ff        <= req_move_speed;
               dwell_ff        <= req_dwell_time;
               now_ff          <= req_now_time;
               res_status_ff   <= ptzs_pkg::ST_OK;
               res_handled_ff  <= 1'b0;
               res_go_valid_ff <= 1'b0;
               res_preset_ff   <= '0;
               res_speed_ff    <= '0;
               res_dwell_ff    <= '0;
            end
            ptzs_pkg::ACT_DECODE: begin
               route_ff <= ptzs_pkg::RT_DONE;
               res_handled_ff <= (cmd_ff == ptzs_pkg::CMD_RUN) && emulated;
               if (cmd_ff > ptzs_pkg::CMD_DELETE) begin
                  res_status_ff <= ptzs_pkg::ST_OK;
               end else if (bad_ch) begin
                  res_status_ff <= ptzs_pkg::ST_BAD_CH;
               end else begin
                  case (cmd_ff)
                     ptzs_pkg::CMD_TICK: begin
                        tsel_ff <= run_tour_ff[ch_ff];
                        if (running_ff[ch_ff]) begin
                           if ((is_late && next_cur != 32'd0 && late_gap > gap_ff) ||
                               (!is_late && early_gap > gap_ff)) begin
                              if (run_point_ff[ch_ff] != '0) begin
                                 ptr_ff   <= {1'b0, run_point_ff[ch_ff] - 1'b1};
                                 route_ff <= ptzs_pkg::RT_JUMP;
                              end else begin
                                 ptr_ff   <= (ptzs_pkg::POINT_W + 1)'(1);
                                 route_ff <= ptzs_pkg::RT_SCAN;
                              end
                           end else if (is_late) begin
                              ptr_ff   <= {1'b0, run_point_ff[ch_ff]};
                              route_ff <= ptzs_pkg::RT_GO;
                           end
                        end
                     end
                     ptzs_pkg::CMD_ENTER: begin
                        if (bad_tour) begin
                           res_status_ff <= ptzs_pkg::ST_BAD_TOUR;
                        end else begin
                           prog_valid_ff[ch_ff] <= 1'b1;
                           prog_tour_ff[ch_ff]  <= tour_ff[ptzs_pkg::TOUR_W-1:0];
                           prog_point_ff[ch_ff] <= '0;
                        end
                     end
                     ptzs_pkg::CMD_SET: begin
                        if (!prog_valid_ff[ch_ff] ||
                            prog_point_ff[ch_ff][ptzs_pkg::POINT_W]) begin
                           res_status_ff <= ptzs_pkg::ST_CURSOR;
                        end else begin
                           prog_point_ff[ch_ff] <= prog_point_ff[ch_ff] + 1'b1;
                        end
                     end
                     ptzs_pkg::CMD_LEAVE: begin
                        if (!prog_valid_ff[ch_ff]) begin
                           res_status_ff <= ptzs_pkg::ST_CURSOR;
                        end else begin
                           tsel_ff  <= prog_tour_ff[ch_ff];
                           ptr_ff   <= prog_point_ff[ch_ff];
                           route_ff <= ptzs_pkg::RT_UNUSE;
                           prog_valid_ff[ch_ff] <= 1'b0;
                           prog_tour_ff[ch_ff]  <= '0;
                           prog_point_ff[ch_ff] <= '0;
                        end
                     end
                     ptzs_pkg::CMD_RUN: begin
                        if (emulated) begin
                           if (bad_tour) begin
                              res_status_ff <= ptzs_pkg::ST_BAD_TOUR;
                           end else if (running_ff[ch_ff]) begin
                              res_status_ff <= ptzs_pkg::ST_RUNNING;
                           end else begin
                              running_ff[ch_ff]   <= 1'b1;
                              run_tour_ff[ch_ff]  <= tour_ff[ptzs_pkg::TOUR_W-1:0];
                              run_point_ff[ch_ff] <= '0;
                              next_due_ff[ch_ff]  <= '0;
                           end
                        end
                     end
                     ptzs_pkg::CMD_STOP: begin
                        running_ff[ch_ff]   <= 1'b0;
                        run_tour_ff[ch_ff]  <= '0;
                        run_point_ff[ch_ff] <= '0;
                        next_due_ff[ch_ff]  <= ptzs_pkg::IDLE_DUE;
                     end
                     default: begin
                        if (bad_tour) begin
                           res_status_ff <= ptzs_pkg::ST_BAD_TOUR;
                        end else begin
                           tsel_ff  <= tour_ff[ptzs_pkg::TOUR_W-1:0];
                           ptr_ff   <= '0;
                           route_ff <= ptzs_pkg::RT_UNUSE;
                        end
                     end
                  endcase
               end
            end
            ptzs_pkg::ACT_UNUSE: begin
               if (!ptr_ff[ptzs_pkg::POINT_W]) begin
                  ptr_ff <= ptr_ff + 1'b1;
               end
            end
            ptzs_pkg::ACT_GO: begin
               if (rd_used_ff) begin
                  res_go_valid_ff <= 1'b1;
                  res_preset_ff   <= rd_data_ff[23:16];
                  res_speed_ff    <= rd_data_ff[15:8];
                  res_dwell_ff    <= rd_data_ff[7:0];
               end
               next_due_ff[ch_ff] <= rearm_due;
               ptr_ff <= {1'b0, ptr_ff[ptzs_pkg::POINT_W-1:0] + 1'b1};
            end
            ptzs_pkg::ACT_GO_NEXT: begin
               run_point_ff[ch_ff] <= rd_used_ff ? ptr_ff[ptzs_pkg::POINT_W-1:0] : '0;
            end
            ptzs_pkg::ACT_SCAN: begin
               if (!rd_used_ff) begin
                  ptr_ff <= ptr_ff - 1'b1;
               end else if (!stat_out.ptr_last) begin
                  ptr_ff <= ptr_ff + 1'b1;
               end
            end
            ptzs_pkg::ACT_REARM: begin
               next_due_ff[ch_ff] <= rearm_due;
            end
            ptzs_pkg::ACT_PUBLISH: begin
               rsp_valid_ff      <= 1'b1;
               rsp_status_ff     <= res_status_ff;
               rsp_handled_ff    <= res_handled_ff;
               rsp_go_valid_ff   <= res_go_valid_ff;
               rsp_go_channel_ff <= res_go_valid_ff ? ch_ff : 4'd0;
               rsp_go_preset_ff  <= res_preset_ff;
               rsp_go_speed_ff   <= res_speed_ff;
               rsp_go_dwell_ff   <= res_dwell_ff;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_handled    = rsp_handled_ff;
   assign rsp_go_valid   = rsp_go_valid_ff;
   assign rsp_go_channel = rsp_go_channel_ff;
   assign rsp_go_preset  = rsp_go_preset_ff;
   assign rsp_go_speed   = rsp_go_speed_ff;
   assign rsp_go_dwell   = rsp_go_dwell_ff;

endmodule

// ===== hw/rtl/ptzs_ctrl.sv =====
// Controller state machine of the preset tour sequencer.
// Sequences clearing, decode, memory sweeps and tick steps; depends on ptzs_pkg.
module ptzs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output ptzs_pkg::dp_cmd_type   cmd_out,
   input  ptzs_pkg::dp_stat_type  stat_in
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_ROUTE, S_UNUSE, S_GO_RD, S_GO_USE, S_GO_RD2,
      S_GO_NEXT, S_J_RD, S_J_SET, S_SC_RD, S_SC_CHK, S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      cmd_out.act = ptzs_pkg::ACT_NONE;
      case (state_ff)
         S_CLEAR: begin
            cmd_out.act = ptzs_pkg::ACT_CLEAR;
            if (stat_in.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_out.act = ptzs_pkg::ACT_LOAD;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd_out.act = ptzs_pkg::ACT_DECODE;
            state_in    = S_ROUTE;
         end
         S_ROUTE: begin
            case (stat_in.route)
               ptzs_pkg::RT_UNUSE: state_in = S_UNUSE;
               ptzs_pkg::RT_GO:    state_in = S_GO_USE;
               ptzs_pkg::RT_JUMP:  state_in = S_J_SET;
               ptzs_pkg::RT_SCAN:  state_in = S_SC_CHK;
               default:            state_in = S_DONE;
            endcase
         end
         S_UNUSE: begin
            cmd_out.act = ptzs_pkg::ACT_UNUSE;
            if (stat_in.ptr_end) state_in = S_DONE;
         end
         S_GO_RD:   state_in = S_GO_USE;
         S_GO_USE: begin
            cmd_out.act = ptzs_pkg::ACT_GO;
            state_in    = S_GO_RD2;
         end
         S_GO_RD2:  state_in = S_GO_NEXT;
         S_GO_NEXT: begin
            cmd_out.act = ptzs_pkg::ACT_GO_NEXT;
            state_in    = S_DONE;
         end
         S_J_RD:    state_in = S_J_SET;
         S_J_SET: begin
            cmd_out.act = ptzs_pkg::ACT_REARM;
            state_in    = S_DONE;
         end
         S_SC_RD:   state_in = S_SC_CHK;
         S_SC_CHK: begin
            cmd_out.act = ptzs_pkg::ACT_SCAN;
            state_in    = (!stat_in.rd_used || stat_in.ptr_last) ? S_J_RD : S_SC_RD;
         end
         S_DONE: begin
            if (stat_in.out_free) begin
               cmd_out.act = ptzs_pkg::ACT_PUBLISH;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

// ===== hw/rtl/ptz_preset_tour_sequencer_unit.sv =====
// Top level of the camera preset tour sequencer.
// Joins ptzs_ctrl and ptzs_datapath; depends on ptzs_pkg.
//
//   port group   direction   handshake
//   req_*        in          req_valid / req_ready
//   rsp_*        out         rsp_valid / rsp_ready
//   csr_*        in          csr_we, no wait
//
// A tick may step the tour or, after a time jump, rearm the due time; a rearm
// from the first point scans the used bits to find the last point;
// leave and delete sweep one point per cycle.
// After reset a clearing pass writes all 2048 table entries, one per cycle,
// before req_ready rises. A waiting result is held in the output register
// while the next item is taken; it stalls only the end of that next item.
module ptz_preset_tour_sequencer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [3:0]  req_channel,
   input  logic [7:0]  req_tour_id,
   input  logic [7:0]  req_preset_id,
   input  logic [7:0]  req_move_speed,
   input  logic [7:0]  req_dwell_time,
   input  logic [31:0] req_now_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic        rsp_handled,
   output logic        rsp_go_valid,
   output logic [3:0]  rsp_go_channel,
   output logic [7:0]  rsp_go_preset,
   output logic [7:0]  rsp_go_speed,
   output logic [7:0]  rsp_go_dwell
);

   ptzs_pkg::dp_cmd_type  dp_cmd;
   ptzs_pkg::dp_stat_type dp_stat;

   ptzs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd_out   (dp_cmd),
      .stat_in   (dp_stat)
   );

   ptzs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd_in         (dp_cmd),
      .stat_out       (dp_stat),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_cmd        (req_cmd),
      .req_channel    (req_channel),
      .req_tour_id    (req_tour_id),
      .req_preset_id  (req_preset_id),
      .req_move_speed (req_move_speed),
      .req_dwell_time (req_dwell_time),
      .req_now_time   (req_now_time),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_handled    (rsp_handled),
      .rsp_go_valid   (rsp_go_valid),
      .rsp_go_channel (rsp_go_channel),
      .rsp_go_preset  (rsp_go_preset),
      .rsp_go_speed   (rsp_go_speed),
      .rsp_go_dwell   (rsp_go_dwell)
   );

endmodule

// ===== bench/tb_ptz_preset_tour_sequencer_unit.sv =====
// Testbench for ptz_preset_tour_sequencer_unit: directed table plus random tours,
// checked against a behavioral tour predictor. Depends on ptzs_pkg and the RTL.
`timescale 1ns / 1ps

module tb_ptz_preset_tour_sequencer_unit;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [3:0]  channel;
      logic [7:0]  tour_id;
      logic [7:0]  preset_id;
      logic [7:0]  move_speed;
      logic [7:0]  dwell_time;
      logic [31:0] now_time;
   } tour_req_type;

   typedef struct packed {
      logic [2:0] status;
      logic       handled;
      logic       go_valid;
      logic [3:0] go_channel;
      logic [7:0] go_preset;
      logic [7:0] go_speed;
      logic [7:0] go_dwell;
   } tour_rsp_type;

   typedef struct packed {
      logic [7:0] preset;
      logic [7:0] speed;
      logic [7:0] dwell;
      logic       used;
   } point_type;

   typedef struct {
      tour_req_type req;
      logic         typed;
      logic [2:0]   status;
      logic         handled;
   } row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [1:0]  csr_index = ptzs_pkg::CSR_CHAN_COUNT;
   logic [31:0] csr_wdata = 0;
   logic        req_valid = 0;
   logic        req_ready;
   logic [2:0]  req_cmd = ptzs_pkg::CMD_TICK;
   logic [3:0]  req_channel = 0;
   logic [7:0]  req_tour_id = 0;
   logic [7:0]  req_preset_id = 0;
   logic [7:0]  req_move_speed = 0;
   logic [7:0]  req_dwell_time = 0;
   logic [31:0] req_now_time = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [2:0]  rsp_status;
   logic        rsp_handled;
   logic        rsp_go_valid;
   logic [3:0]  rsp_go_channel;
   logic [7:0]  rsp_go_preset;
   logic [7:0]  rsp_go_speed;
   logic [7:0]  rsp_go_dwell;

   ptz_preset_tour_sequencer_unit dut (.*);

   always #2 clock = ~clock;

   // predictor state
   point_type   tours_q [ptzs_pkg::CHANNELS][ptzs_pkg::TOURS][ptzs_pkg::POINTS];
   logic        prog_on [ptzs_pkg::CHANNELS];
   int unsigned prog_tr [ptzs_pkg::CHANNELS];
   int unsigned prog_pt [ptzs_pkg::CHANNELS];
   logic        run_on [ptzs_pkg::CHANNELS];
   int unsigned run_tr [ptzs_pkg::CHANNELS];
   int unsigned run_pt [ptzs_pkg::CHANNELS];
   logic [31:0] due_at [ptzs_pkg::CHANNELS];
   logic [4:0]  chan_count;
   logic [15:0] emu_mask;
   logic [31:0] dwell_gap;

   tour_rsp_type pending_rsp [$];
   int           fails = 0;
   int           rsp_seen = 0;
   int           go_seen = 0;
   int           idle_cycles = 0;
   logic         calm = 0;

   function automatic int unsigned prior_point(int unsigned ch, int unsigned t,
                                               int unsigned p);
      if (p > 0) return p - 1;
      for (int q = 1; q < ptzs_pkg::POINTS; q++)
         if (!tours_q[ch][t][q].used) return q - 1;
      return ptzs_pkg::POINTS - 1;
   endfunction

   function automatic void halt(int unsigned ch);
      run_on[ch] = 0;
      run_tr[ch] = 0;
      run_pt[ch] = 0;
      due_at[ch] = ptzs_pkg::IDLE_DUE;
   endfunction

   function automatic void reset_tours();
      for (int c = 0; c < ptzs_pkg::CHANNELS; c++) begin
         for (int t = 0; t < ptzs_pkg::TOURS; t++)
            for (int p = 0; p < ptzs_pkg::POINTS; p++) tours_q[c][t][p] = '0;
         prog_on[c] = 0;
         prog_tr[c] = 0;
         prog_pt[c] = 0;
         halt(c);
      end
      chan_count = 5'd16;
      emu_mask = 0;
      dwell_gap = 255;
   endfunction

   function automatic tour_rsp_type predict_tour(tour_req_type r);
      tour_rsp_type o;
      int unsigned  ch, t, p, q;
      logic [31:0]  nxt;
      logic         emu;
      o = '0;
      ch = r.channel;
      emu = emu_mask[ch];
      if (r.cmd == ptzs_pkg::CMD_RUN) o.handled = emu;
      if (r.cmd > ptzs_pkg::CMD_DELETE) return o;
      if (ch >= chan_count) begin
         o.status = ptzs_pkg::ST_BAD_CH;
         return o;
      end
      case (r.cmd)
         ptzs_pkg::CMD_TICK: if (run_on[ch]) begin
            t = run_tr[ch];
            p = run_pt[ch];
            nxt = due_at[ch];
            if (r.now_time > nxt) begin
               if (nxt != 0 && (r.now_time - nxt) > dwell_gap) begin
                  q = prior_point(ch, t, p);
                  due_at[ch] = r.now_time + tours_q[ch][t][q].dwell;
               end else begin
                  if (tours_q[ch][t][p].used) begin
                     o.go_valid = 1;
                     o.go_channel = 4'(ch);
                     o.go_preset = tours_q[ch][t][p].preset;
                     o.go_speed = tours_q[ch][t][p].speed;
                     o.go_dwell = tours_q[ch][t][p].dwell;
                  end
                  due_at[ch] = r.now_time + tours_q[ch][t][p].dwell;
                  p = (p + 1) % ptzs_pkg::POINTS;
                  if (!tours_q[ch][t][p].used) p = 0;
                  run_pt[ch] = p;
               end
            end else if ((nxt - r.now_time) > dwell_gap) begin
               q = prior_point(ch, t, p);
               due_at[ch] = r.now_time + tours_q[ch][t][q].dwell;
            end
         end
         ptzs_pkg::CMD_ENTER: if (r.tour_id >= ptzs_pkg::TOURS) o.status = ptzs_pkg::ST_BAD_TOUR;
         else begin
            prog_on[ch] = 1;
            prog_tr[ch] = r.tour_id;
            prog_pt[ch] = 0;
         end
         ptzs_pkg::CMD_SET: if (!prog_on[ch] || prog_pt[ch] >= ptzs_pkg::POINTS)
            o.status = ptzs_pkg::ST_CURSOR;
         else begin
            tours_q[ch][prog_tr[ch]][prog_pt[ch]] =
               {r.preset_id, r.move_speed, r.dwell_time, 1'b1};
            prog_pt[ch]++;
         end
         ptzs_pkg::CMD_LEAVE: if (!prog_on[ch]) o.status = ptzs_pkg::ST_CURSOR;
         else begin
            for (int i = prog_pt[ch]; i < ptzs_pkg::POINTS; i++)
               tours_q[ch][prog_tr[ch]][i].used = 0;
            prog_on[ch] = 0;
            prog_tr[ch] = 0;
            prog_pt[ch] = 0;
         end
         ptzs_pkg::CMD_RUN: if (emu) begin
            if (r.tour_id >= ptzs_pkg::TOURS) o.status = ptzs_pkg::ST_BAD_TOUR;
            else if (run_on[ch]) o.status = ptzs_pkg::ST_RUNNING;
            else begin
               run_on[ch] = 1;
               run_tr[ch] = r.tour_id;
               run_pt[ch] = 0;
               due_at[ch] = 0;
            end
         end
         ptzs_pkg::CMD_STOP: halt(ch);
         default: if (r.tour_id >= ptzs_pkg::TOURS) o.status = ptzs_pkg::ST_BAD_TOUR;
         else for (int i = 0; i < ptzs_pkg::POINTS; i++) tours_q[ch][r.tour_id][i].used = 0;
      endcase
      return o;
   endfunction

   // stall the result side
   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= calm || ($urandom_range(99) >= 33);
   end

   always @(posedge clock) begin
      tour_rsp_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_status, rsp_handled, rsp_go_valid, rsp_go_channel,
                rsp_go_preset, rsp_go_speed, rsp_go_dwell};
         rsp_seen++;
         if (got.go_valid) go_seen++;
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected result %h", $time, got);
            fails++;
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) begin
               $display("%0t result: expected %h actual %h", $time, want, got);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("ptz_preset_tour_sequencer_unit: mismatch");
         $finish;
      end
   end

   task automatic send_item(tour_req_type r, logic typed, logic [2:0] st, logic hd);
      tour_rsp_type e;
      do @(posedge clock); while (!calm && $urandom_range(99) < 33);
      req_valid <= 1;
      {req_cmd, req_channel, req_tour_id, req_preset_id, req_move_speed,
       req_dwell_time, req_now_time} <= r;
      do @(posedge clock); while (!req_ready);
      req_valid <= 0;
      e = predict_tour(r);
      if (typed && (e.status !== st || e.handled !== hd)) begin
         $display("%0t table row: expected %0d/%0d predicted %0d/%0d",
                  $time, st, hd, e.status, e.handled);
         fails++;
      end
      pending_rsp.push_back(e);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         ptzs_pkg::CSR_CHAN_COUNT: chan_count = val[4:0];
         ptzs_pkg::CSR_EMU_MASK:   emu_mask = val[15:0];
         ptzs_pkg::CSR_DWELL_GAP:  dwell_gap = val;
         default: ;
      endcase
   endtask

   function automatic tour_req_type mk(logic [2:0] c, logic [3:0] ch, logic [7:0] t,
                                       logic [7:0] p, logic [7:0] s, logic [7:0] d,
                                       logic [31:0] n);
      return {c, ch, t, p, s, d, n};
   endfunction

   function automatic tour_req_type rand_item(int unsigned ch_hi);
      tour_req_type r;
      int unsigned  k;
      r = {$urandom, $urandom};
      k = $urandom_range(99);
      r.cmd = k < 45 ? ptzs_pkg::CMD_TICK : k < 55 ? ptzs_pkg::CMD_ENTER :
              k < 75 ? ptzs_pkg::CMD_SET : k < 82 ? ptzs_pkg::CMD_LEAVE :
              k < 90 ? ptzs_pkg::CMD_RUN : k < 94 ? ptzs_pkg::CMD_STOP :
              k < 98 ? ptzs_pkg::CMD_DELETE : 3'd7;
      r.channel = 4'(($urandom_range(9) == 0) ? $urandom : $urandom_range(ch_hi));
      if ($urandom_range(9) != 0) r.tour_id = 8'($urandom_range(ptzs_pkg::TOURS - 1));
      return r;
   endfunction

   row_type     rows [$];
   logic [31:0] clock_now [ptzs_pkg::CHANNELS];

   initial begin
      reset_tours();
      repeat (3) @(posedge clock);
      reset <= 0;
      rows = '{
         '{mk(ptzs_pkg::CMD_SET, 0, 0, 1, 1, 1, 0), 1, ptzs_pkg::ST_CURSOR, 0},
         '{mk(ptzs_pkg::CMD_LEAVE, 0, 0, 0, 0, 0, 0), 1, ptzs_pkg::ST_CURSOR, 0},
         '{mk(ptzs_pkg::CMD_ENTER, 0, 8, 0, 0, 0, 0), 1, ptzs_pkg::ST_BAD_TOUR, 0},
         '{mk(ptzs_pkg::CMD_ENTER, 15, 255, 0, 0, 0, 0), 1, ptzs_pkg::ST_BAD_TOUR, 0},
         '{mk(ptzs_pkg::CMD_RUN, 3, 0, 0, 0, 0, 0), 1, ptzs_pkg::ST_OK, 0},
         '{mk(3'd7, 15, 255, 255, 255, 255, 32'hffffffff), 1, ptzs_pkg::ST_OK, 0},
         '{mk(ptzs_pkg::CMD_TICK, 2, 0, 0, 0, 0, 5), 1, ptzs_pkg::ST_OK, 0},
         '{mk(ptzs_pkg::CMD_ENTER, 1, 7, 0, 0, 0, 0), 1, ptzs_pkg::ST_OK, 0},
         '{mk(ptzs_pkg::CMD_SET, 1, 0, 255, 255, 255, 0), 1, ptzs_pkg::ST_OK, 0},
         '{mk(ptzs_pkg::CMD_SET, 1, 0, 0, 0, 0, 0), 1, ptzs_pkg::ST_OK, 0},
         '{mk(ptzs_pkg::CMD_SET, 1, 0, 17, 34, 10, 0), 1, ptzs_pkg::ST_OK, 0},
         '{mk(ptzs_pkg::CMD_LEAVE, 1, 0, 0, 0, 0, 0), 1, ptzs_pkg::ST_OK, 0},
         '{mk(ptzs_pkg::CMD_DELETE, 1, 200, 0, 0, 0, 0), 1, ptzs_pkg::ST_BAD_TOUR, 0},
         '{mk(ptzs_pkg::CMD_DELETE, 1, 3, 0, 0, 0, 0), 1, ptzs_pkg::ST_OK, 0}
      };
      foreach (rows[i]) send_item(rows[i].req, rows[i].typed, rows[i].status, rows[i].handled);

      write_csr(ptzs_pkg::CSR_EMU_MASK, 32'hffff);
      write_csr(ptzs_pkg::CSR_DWELL_GAP, 32'hffffffff);
      rows = '{
         '{mk(ptzs_pkg::CMD_RUN, 1, 8, 0, 0, 0, 0), 1, ptzs_pkg::ST_BAD_TOUR, 1},
         '{mk(ptzs_pkg::CMD_RUN, 1, 7, 0, 0, 0, 0), 1, ptzs_pkg::ST_OK, 1},
         '{mk(ptzs_pkg::CMD_RUN, 1, 7, 0, 0, 0, 0), 1, ptzs_pkg::ST_RUNNING, 1},
         '{mk(ptzs_pkg::CMD_TICK, 1, 0, 0, 0, 0, 0), 0, 0, 0},
         '{mk(ptzs_pkg::CMD_TICK, 1, 0, 0, 0, 0, 1), 0, 0, 0},
         '{mk(ptzs_pkg::CMD_TICK, 1, 0, 0, 0, 0, 300), 0, 0, 0},
         '{mk(ptzs_pkg::CMD_TICK, 1, 0, 0, 0, 0, 301), 0, 0, 0},
         '{mk(ptzs_pkg::CMD_TICK, 1, 0, 0, 0, 0, 32'hffffffff), 0, 0, 0},
         '{mk(ptzs_pkg::CMD_STOP, 1, 0, 0, 0, 0, 0), 1, ptzs_pkg::ST_OK, 0}
      };
      foreach (rows[i]) send_item(rows[i].req, rows[i].typed, rows[i].status, rows[i].handled);

      write_csr(ptzs_pkg::CSR_CHAN_COUNT, 1);
      send_item(mk(ptzs_pkg::CMD_ENTER, 1, 0, 0, 0, 0, 0), 1, ptzs_pkg::ST_BAD_CH, 0);
      write_csr(ptzs_pkg::CSR_DWELL_GAP, 0);
      send_item(mk(ptzs_pkg::CMD_RUN, 0, 0, 0, 0, 0, 0), 0, 0, 0);
      send_item(mk(ptzs_pkg::CMD_TICK, 0, 0, 0, 0, 0, 9), 0, 0, 0);
      send_item(mk(ptzs_pkg::CMD_TICK, 0, 0, 0, 0, 0, 20), 0, 0, 0);

      foreach (clock_now[c]) clock_now[c] = $urandom_range(1000);
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_csr(ptzs_pkg::CSR_CHAN_COUNT, 16);
               write_csr(ptzs_pkg::CSR_DWELL_GAP, 600);
            end
            1: begin
               write_csr(ptzs_pkg::CSR_CHAN_COUNT, 5);
               write_csr(ptzs_pkg::CSR_EMU_MASK, $urandom);
            end
            2: begin
               write_csr(ptzs_pkg::CSR_CHAN_COUNT, 16);
               write_csr(ptzs_pkg::CSR_DWELL_GAP, 32'hffffffff);
            end
            default: begin
               write_csr(ptzs_pkg::CSR_EMU_MASK, 16'hffff);
               write_csr(ptzs_pkg::CSR_DWELL_GAP, 100);
            end
         endcase
         calm = (phase == 2);
         for (int n = 0; n < 170; n++) begin
            tour_req_type r;
            int unsigned  j;
            r = rand_item(phase == 1 ? 5 : 3);
            if ($urandom_range(3) != 0 && r.cmd != 3'd7) begin
               // program a short tour, run it and tick through it
               j = $urandom_range(4) + 1;
               send_item(mk(ptzs_pkg::CMD_ENTER, r.channel, r.tour_id, 0, 0, 0, 0),
                         0, 0, 0);
               for (int k = 0; k < j; k++)
                  send_item(mk(ptzs_pkg::CMD_SET, r.channel, 0, 8'($urandom),
                               8'($urandom), 8'($urandom_range(60)), 0), 0, 0, 0);
               send_item(mk(ptzs_pkg::CMD_LEAVE, r.channel, 0, 0, 0, 0, 0), 0, 0, 0);
               send_item(mk(ptzs_pkg::CMD_RUN, r.channel, r.tour_id, 0, 0, 0, 0),
                         0, 0, 0);
               for (int k = 0; k < 6; k++) begin
                  clock_now[r.channel] += ($urandom_range(19) == 0) ? $urandom
                                          : $urandom_range(70);
                  send_item(mk(ptzs_pkg::CMD_TICK, r.channel, 0, 0, 0, 0,
                               clock_now[r.channel]), 0, 0, 0);
               end
               n += j + 9;
               if ($urandom_range(2) == 0)
                  send_item(mk(ptzs_pkg::CMD_STOP, r.channel, 0, 0, 0, 0, 0), 0, 0, 0);
            end else
               send_item(r, 0, 0, 0);
         end
      end

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("covered %0d results, %0d preset-go moves, over four register settings",
               rsp_seen, go_seen);
      if (fails == 0)
         $display("ptz_preset_tour_sequencer_unit: match");
      else
         $display("ptz_preset_tour_sequencer_unit: mismatch");
      $finish;
   end
endmodule
